// ----- sv/arp_pkg.sv -----
// Shared types, sizes and codes for the ARP cache table.
`default_nettype none

package arp_pkg;

  localparam int ENTRIES     = 16;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SLOT_W      = 4;
  // The queue depth must be a power of two so that the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [31:0]          ip_t;
  typedef logic [47:0]          mac_t;
  typedef logic [7:0]           tag_t;
  typedef logic [1:0]           entry_state_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QCNT_W-1:0]    qcnt_t;

  localparam logic CMD_SET    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam entry_state_t ST_INVALID = 2'd0;
  localparam entry_state_t ST_PENDING = 2'd1;
  localparam entry_state_t ST_VALID   = 2'd2;

  typedef struct packed {
    logic         command;
    ip_t          ip_addr;
    mac_t         mac_addr;
    entry_state_t new_state;
    logic         has_waiter;
    tag_t         waiter_tag;
  } req_t;

  typedef struct packed {
    logic  hit;
    mac_t  mac_out;
    slot_t slot;
    logic  wake_valid;
    tag_t  wake_tag;
  } rsp_t;

  // A classified item as it waits in the queue for the table engine.
  typedef struct packed {
    logic         is_set;
    logic         resolves;
    ip_t          ip;
    mac_t         mac;
    entry_state_t new_state;
    logic         has_waiter;
    tag_t         waiter;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/arp_cache_table.sv -----
// ARP cache table top level: wires the request queue front end to the table engine.
`default_nettype none

// A 16-entry IPv4-to-MAC table. Request items (set or lookup) enter a two-deep
// queue and the table engine handles one item at a time, each producing exactly one
// result item. A lookup, or a set that finds a free entry or one with the same IP,
// passes through the engine in order: take from the queue, parallel compare over all
// entries, then write-back and result register, which waits while a stalled result
// still holds the register. A set that must evict first walks the stored use times one
// entry per cycle to find the oldest. Requests keep flowing into the queue while the
// engine works, until it is full, and a finished result waits in its register without
// blocking the queue. Entries reset to invalid at once; no clearing pass is needed.
module arp_cache_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  arp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output arp_pkg::rsp_t rsp
);

  logic          job_valid;
  logic          job_take;
  arp_pkg::job_t job;

  arp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  arp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- sv/arp_front.sv -----
// Front end: accepts request items, classifies them and queues them for the table engine.
`default_nettype none

module arp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  arp_pkg::req_t req,
  output logic          job_valid,
  input  logic          job_take,
  output arp_pkg::job_t job
);

  arp_pkg::job_t  fifo [arp_pkg::QUEUE_DEPTH];
  arp_pkg::qptr_t wr_ptr;
  arp_pkg::qptr_t rd_ptr;
  arp_pkg::qcnt_t count;
  arp_pkg::job_t  classified;
  logic           push;
  logic           pop;

  always_comb begin
    classified.is_set     = (req.command == arp_pkg::CMD_SET);
    classified.resolves   = (req.new_state == arp_pkg::ST_VALID);
    classified.ip         = req.ip_addr;
    classified.mac        = req.mac_addr;
    classified.new_state  = req.new_state;
    classified.has_waiter = req.has_waiter;
    classified.waiter     = req.has_waiter ? req.waiter_tag : '0;
  end

  assign req_stall = (count == arp_pkg::qcnt_t'(arp_pkg::QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign pop       = job_valid && job_take;
  assign job_valid = (count != '0);
  assign job       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= classified;
    end
  end

endmodule

`default_nettype wire

// ----- sv/arp_back.sv -----
// Back end: the entry store, the match and age-scan sequencer and the result register.
`default_nettype none

module arp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_take,
  input  arp_pkg::job_t job,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output arp_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_LOOK  = 4'b0010,
    B_SCAN  = 4'b0100,
    B_WRITE = 4'b1000
  } back_state_t;

  back_state_t state;
  arp_pkg::job_t  cur;
  arp_pkg::time_t use_counter;
  arp_pkg::idx_t  sel;
  logic           found;
  arp_pkg::idx_t  scan_idx;
  arp_pkg::time_t best_age;

  arp_pkg::entry_state_t     slot_state  [arp_pkg::ENTRIES];
  arp_pkg::ip_t              slot_ip     [arp_pkg::ENTRIES];
  arp_pkg::mac_t             slot_mac    [arp_pkg::ENTRIES];
  arp_pkg::time_t            slot_time   [arp_pkg::ENTRIES];
  logic [arp_pkg::ENTRIES-1:0] slot_wpres;
  arp_pkg::tag_t             slot_waiter [arp_pkg::ENTRIES];

  logic [arp_pkg::ENTRIES-1:0] pick_vec;
  arp_pkg::idx_t  first_idx;
  logic           any;
  arp_pkg::time_t scan_age;
  arp_pkg::time_t age0;
  logic           out_free;
  logic           wake;
  arp_pkg::rsp_t  result;

  // A set claims the first free or same-address entry; a lookup wants the first valid match.
  always_comb begin
    for (int i = 0; i < arp_pkg::ENTRIES; i++) begin
      if (cur.is_set) begin
        pick_vec[i] = (slot_state[i] == arp_pkg::ST_INVALID) || (slot_ip[i] == cur.ip);
      end else begin
        pick_vec[i] = (slot_state[i] == arp_pkg::ST_VALID) && (slot_ip[i] == cur.ip);
      end
    end
    first_idx = '0;
    for (int i = arp_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (pick_vec[i]) begin
        first_idx = arp_pkg::idx_t'(i);
      end
    end
  end

  assign any      = |pick_vec;
  assign scan_age = use_counter - slot_time[scan_idx];
  assign age0     = use_counter - slot_time[0];
  assign out_free = !rsp_valid || !rsp_stall;
  assign job_take = (state == B_IDLE) && job_valid;

  assign wake = cur.is_set && (slot_state[sel] == arp_pkg::ST_PENDING) &&
                slot_wpres[sel] && cur.resolves;

  always_comb begin
    result.hit        = cur.is_set || found;
    result.mac_out    = (!cur.is_set && found) ? slot_mac[sel] : '0;
    result.slot       = arp_pkg::slot_t'(sel);
    result.wake_valid = wake;
    result.wake_tag   = wake ? slot_waiter[sel] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      use_counter <= '0;
      rsp_valid   <= 1'b0;
      slot_wpres  <= '0;
      for (int i = 0; i < arp_pkg::ENTRIES; i++) begin
        slot_state[i] <= arp_pkg::ST_INVALID;
      end
    end else begin
      // In the write state a drained result is replaced by the new one below.
      if (rsp_valid && !rsp_stall && (state != B_WRITE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_LOOK;
            if (job.is_set) begin
              use_counter <= use_counter + 1'b1;
            end
          end
        end
        B_LOOK: begin
          state <= (cur.is_set && !any) ? B_SCAN : B_WRITE;
        end
        B_SCAN: begin
          if (scan_idx == arp_pkg::idx_t'(arp_pkg::ENTRIES - 1)) begin
            state <= B_WRITE;
          end
        end
        B_WRITE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= B_IDLE;
            if (cur.is_set) begin
              slot_state[sel] <= cur.new_state;
              slot_wpres[sel] <= cur.has_waiter;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          cur <= job;
        end
      end
      B_LOOK: begin
        sel      <= any ? first_idx : '0;
        found    <= any;
        best_age <= age0;
        scan_idx <= arp_pkg::idx_t'(1);
      end
      B_SCAN: begin
        // Strictly greater keeps the lowest index among equally old entries.
        if (scan_age > best_age) begin
          best_age <= scan_age;
          sel      <= scan_idx;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      B_WRITE: begin
        if (out_free) begin
          rsp <= result;
          if (cur.is_set) begin
            slot_ip[sel]     <= cur.ip;
            slot_mac[sel]    <= cur.mac;
            slot_time[sel]   <= use_counter;
            slot_waiter[sel] <= cur.waiter;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/arp_check.sv -----
// Port-level checks for the ARP cache table and their binding to the top level.
`default_nettype none

module arp_check (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input arp_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result item changed while stalled");

  a_wake_on_set: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake_valid |-> rsp.hit && (rsp.mac_out == '0))
    else $error("wake reported on a result that is not a set");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |->
      (rsp.slot == '0) && (rsp.mac_out == '0) && !rsp.wake_valid && (rsp.wake_tag == '0))
    else $error("miss result carries stray fields");

  a_no_early_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result item appeared right after reset");

endmodule

bind arp_cache_table arp_check u_arp_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
